FILE: design/clnw_pkg.sv
package clnw_pkg;

   localparam int LINE_CHARS = 16;
   localparam int POS_W      = $clog2(2 * LINE_CHARS + 1);
   localparam int PC_W       = 6;

   typedef enum logic [2:0] {
      OP_INIT         = 3'd0,
      OP_COMMAND      = 3'd1,
      OP_RAW_CHAR     = 3'd2,
      OP_STRING_CHAR  = 3'd3,
      OP_STRING_CLEAR = 3'd4,
      OP_STRING_START = 3'd5,
      OP_GOTO         = 3'd6
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_POWER_UP_WAIT = 2'd0,
      CSR_FIRST_STROBE  = 2'd1,
      CSR_STROBE_WAIT   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      NIB_CONST   = 2'd0,
      NIB_DATA_HI = 2'd1,
      NIB_DATA_LO = 2'd2
   } nib_sel_type;

   typedef enum logic [1:0] {
      WAIT_ZERO   = 2'd0,
      WAIT_POWER  = 2'd1,
      WAIT_FIRST  = 2'd2,
      WAIT_STROBE = 2'd3
   } wait_sel_type;

   typedef struct packed {
      nib_sel_type  nib_sel;
      logic [3:0]   nib_const;
      logic         reg_select;
      logic         enable;
      wait_sel_type wait_sel;
      logic         last;
   } ucode_word_type;

   localparam logic [PC_W-1:0] PC_INIT   = PC_W'(0);
   localparam logic [PC_W-1:0] PC_CMD    = PC_W'(29);
   localparam logic [PC_W-1:0] PC_ROW2   = PC_W'(33);
   localparam logic [PC_W-1:0] PC_CHAR   = PC_W'(37);
   localparam logic [PC_W-1:0] PC_CLEAR  = PC_W'(41);
   localparam logic [PC_W-1:0] PC_END    = PC_W'(44);

   localparam logic [7:0] CMD_LINE2 = 8'hC0;
   localparam logic [7:0] CMD_LINE1 = 8'h80;
   localparam logic [7:0] CMD_CLEAR = 8'h01;

   function automatic ucode_word_type uw(nib_sel_type s, logic [3:0] c, logic rs,
                                         logic en, wait_sel_type w, logic last);
      ucode_word_type r;
      r.nib_sel    = s;
      r.nib_const  = c;
      r.reg_select = rs;
      r.enable     = en;
      r.wait_sel   = w;
      r.last       = last;
      return r;
   endfunction

   // four phases of one byte: high nibble strobe, high low, low strobe, low low
   function automatic ucode_word_type const_byte_step(logic [7:0] b, logic [1:0] k,
                                                      logic last);
      logic [3:0] nib;
      nib = k[1] ? b[3:0] : b[7:4];
      return uw(NIB_CONST, nib, 1'b0, ~k[0], k[0] ? WAIT_ZERO : WAIT_STROBE,
                last & (k == 2'd3));
   endfunction

   function automatic ucode_word_type data_byte_step(logic rs, logic [1:0] k);
      return uw(k[1] ? NIB_DATA_LO : NIB_DATA_HI, 4'h0, rs, ~k[0],
                k[0] ? WAIT_ZERO : WAIT_STROBE, k == 2'd3);
   endfunction

   function automatic logic [7:0] init_byte(logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = 8'h28;
         3'd1:    r = 8'h08;
         3'd2:    r = 8'h01;
         3'd3:    r = 8'h06;
         default: r = 8'h0C;
      endcase
      return r;
   endfunction

   function automatic ucode_word_type ucode_rom(logic [PC_W-1:0] pc);
      ucode_word_type r;
      logic [PC_W-1:0] off;
      off = '0;
      if (pc == PC_INIT) begin
         r = uw(NIB_CONST, 4'h0, 1'b0, 1'b0, WAIT_POWER, 1'b0);
      end else if (pc <= PC_W'(8)) begin
         r = uw(NIB_CONST, (pc >= PC_W'(7)) ? 4'h2 : 4'h3, 1'b0, pc[0],
                pc[0] ? ((pc == PC_W'(1)) ? WAIT_FIRST : WAIT_STROBE) : WAIT_ZERO,
                1'b0);
      end else if (pc < PC_CMD) begin
         off = pc - PC_W'(9);
         r = const_byte_step(init_byte(off[4:2]), off[1:0], pc == (PC_CMD - PC_W'(1)));
      end else if (pc < PC_ROW2) begin
         off = pc - PC_CMD;
         r = data_byte_step(1'b0, off[1:0]);
      end else if (pc < PC_CHAR) begin
         off = pc - PC_ROW2;
         r = const_byte_step(CMD_LINE2, off[1:0], 1'b0);
      end else if (pc < PC_CLEAR) begin
         off = pc - PC_CHAR;
         r = data_byte_step(1'b1, off[1:0]);
      end else begin
         off = pc - PC_CLEAR;
         r = const_byte_step(CMD_CLEAR, off[1:0], 1'b1);
      end
      return r;
   endfunction

endpackage

FILE: design/char_lcd_nibble_writer_unit.sv
// channel | ports           | beat contents (low bit up)
// req     | req_tdata       | opcode[2:0] data_byte[10:3] column[18:11] row[26:19]
// rsp     | rsp_tdata/tlast | reg_select read_write enable bus_nibble[3:0] wait_ms[7:0]; last
// csr     | csr_we          | csr_index selects the register, csr_wdata the value
// One bus phase leaves per cycle while rsp_tready is high; a byte is four phases.
// A string char on the line break sends the line-2 command before the char; init sends
// the wake-up nibbles and then the init bytes; a request without output only updates state.
// The step counter of the control store sets the pace; rsp_tready low holds it.
// reset clears the sequencer, string position and output valid, and reloads csrs.
module char_lcd_nibble_writer_unit import clnw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // opcode, data_byte, column, row
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // reg_select, read_write, enable, bus_nibble, wait_ms
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0]      power_wait_ff, first_wait_ff, strobe_wait_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [7:0]      data_ff, data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [14:0]     rsp_data_ff, rsp_data_in;
   logic            rsp_last_ff, rsp_last_in;

   logic [2:0]      op;
   logic [7:0]      in_data, in_col, in_row;
   logic            accept, step;
   ucode_word_type  word;
   logic [3:0]      nib;
   logic [7:0]      wait_val;

   assign op      = req_tdata[2:0];
   assign in_data = req_tdata[10:3];
   assign in_col  = req_tdata[18:11];
   assign in_row  = req_tdata[26:19];

   assign req_tready = ~busy_ff;
   assign accept     = req_tvalid & ~busy_ff;
   assign step       = busy_ff & (~rsp_valid_ff | rsp_tready);
   assign word       = ucode_rom(pc_ff);

   always_comb begin
      case (word.nib_sel)
         NIB_DATA_HI: nib = data_ff[7:4];
         NIB_DATA_LO: nib = data_ff[3:0];
         default:     nib = word.nib_const;
      endcase
      case (word.wait_sel)
         WAIT_POWER:  wait_val = power_wait_ff;
         WAIT_FIRST:  wait_val = first_wait_ff;
         WAIT_STROBE: wait_val = strobe_wait_ff;
         default:     wait_val = 8'd0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      data_in = data_ff;
      pos_in  = pos_ff;
      if (accept) begin
         data_in = in_data;
         case (op)
            OP_INIT: begin
               busy_in = 1'b1;
               pc_in   = PC_INIT;
            end
            OP_COMMAND: begin
               busy_in = 1'b1;
               pc_in   = PC_CMD;
            end
            OP_RAW_CHAR: begin
               busy_in = 1'b1;
               pc_in   = PC_CHAR;
            end
            OP_STRING_CHAR: begin
               if (pos_ff < POS_W'(2 * LINE_CHARS)) begin
                  busy_in = 1'b1;
                  pc_in   = (pos_ff == POS_W'(LINE_CHARS)) ? PC_ROW2 : PC_CHAR;
                  pos_in  = pos_ff + POS_W'(1);
               end
            end
            OP_STRING_CLEAR: begin
               busy_in = 1'b1;
               pc_in   = PC_CLEAR;
               pos_in  = '0;
            end
            OP_STRING_START: begin
               pos_in = '0;
            end
            OP_GOTO: begin
               data_in = ((in_row == 8'd0) ? CMD_LINE1 : CMD_LINE2) + in_col;
               if (in_col < 8'(LINE_CHARS) && (in_row == 8'd0 || in_row == 8'd1)) begin
                  busy_in = 1'b1;
                  pc_in   = PC_CMD;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end else if (step) begin
         busy_in = ~word.last;
         pc_in   = (pc_ff == PC_END) ? pc_ff : pc_ff + PC_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {wait_val, nib, word.enable, 1'b0, word.reg_select};
         rsp_last_in  = word.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_wait_ff  <= 8'd70;
         first_wait_ff  <= 8'd6;
         strobe_wait_ff <= 8'd2;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POWER_UP_WAIT: power_wait_ff  <= csr_wdata;
            CSR_FIRST_STROBE:  first_wait_ff  <= csr_wdata;
            CSR_STROBE_WAIT:   strobe_wait_ff <= csr_wdata;
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= PC_INIT;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: design/clnw_checker.sv
module clnw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_write_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1] == 1'b0 && rsp_tdata[15] == 1'b0)
      else $error("read_write or pad bit set");

   a_last_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[2] == 1'b0 && rsp_tdata[14:7] == 8'd0)
      else $error("last phase is not an enable-low phase");

   a_power_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] && rsp_tdata[14:7] != 8'd0
      |-> rsp_tdata[6:3] == 4'd0 && rsp_tdata[0] == 1'b0)
      else $error("enable-low phase with wait is not the all-low phase");

endmodule

bind char_lcd_nibble_writer_unit clnw_checker u_clnw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
